>>> hdl/pcpm_pkg.sv
`default_nettype none

package pcpm_pkg;

  localparam int NumChannels = 8;

  localparam logic [1:0]  ClipRunMax = 2'd3;
  localparam logic [30:0] LevelOne   = 31'h4000_0000;

  typedef enum logic [1:0] {
    WidthW8  = 2'd0,
    WidthW16 = 2'd1,
    WidthW24 = 2'd2,
    WidthW32 = 2'd3
  } width_e;

  localparam width_e WidthReset = WidthW16;

  // Front end output: one conditioned sample
  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] level;
    logic [30:0] level_abs;
    logic        clipped;
    logic        first;
  } sample_t;

  // One finished result
  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] level;
    logic [30:0] peak;
    logic        over;
    logic        clipped;
  } result_t;

  function automatic logic [31:0] full_scale(width_e mode);
    logic [31:0] fs;
    unique case (mode)
      WidthW8:  fs = 32'h0000_007f;
      WidthW16: fs = 32'h0000_7fff;
      WidthW24: fs = 32'h007f_ffff;
      WidthW32: fs = 32'h7fff_ffff;
      default:  fs = 32'h0000_7fff;
    endcase
    return fs;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pcm_capture_clip_and_peak_meter.sv
// An item is registered in stage one, then in the output register.
// Throughput: one item per cycle unless the output stalls; each channel's
// memory read-modify-write forwards the write of the item ahead of it.
// Reset: sample width returns to 16 bit, every channel reads as zero peak
// and zero clip run through per-entry valid flags, with no clearing pass.
`default_nettype none

module pcm_capture_clip_and_peak_meter import pcpm_pkg::*; #(
  parameter int Channels = NumChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        raw_word_i,
  input  logic [2:0]         channel_i,
  input  logic               first_of_block_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         channel_out_o,
  output logic signed [31:0] level_sample_o,
  output logic [30:0]        peak_level_o,
  output logic               over_flag_o,
  output logic               clipped_o
);

  width_e  mode_q;
  sample_t sample;
  result_t result;
  result_t out_q;
  logic    out_valid_q;
  logic    s1_valid;
  logic    adv;
  logic    in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= WidthReset;
    end else if (cfg_we_i) begin
      mode_q <= width_e'(cfg_wdata_i);
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  pcpm_front u_front (
    .mode_i           (mode_q),
    .raw_word_i       (raw_word_i),
    .channel_i        (channel_i),
    .first_of_block_i (first_of_block_i),
    .sample_o         (sample)
  );

  pcpm_chan_mem #(
    .Channels (Channels)
  ) u_chan_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .sample_i   (sample),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign channel_out_o  = out_q.channel;
  assign level_sample_o = $signed(out_q.level);
  assign peak_level_o   = out_q.peak;
  assign over_flag_o    = out_q.over;
  assign clipped_o      = out_q.clipped;

endmodule

`default_nettype wire

>>> hdl/pcpm_front.sv
`default_nettype none

module pcpm_front import pcpm_pkg::*; (
  input  width_e      mode_i,
  input  logic [31:0] raw_word_i,
  input  logic [2:0]  channel_i,
  input  logic        first_of_block_i,
  output sample_t     sample_o
);

  logic [31:0] sx;
  logic [31:0] mag;
  logic [31:0] fs;
  logic        clip;
  logic [30:0] magc;
  logic [29:0] frac;
  logic [30:0] level_abs;

  always_comb begin
    unique case (mode_i)
      WidthW8:  sx = {{24{raw_word_i[7]}}, raw_word_i[7:0]};
      WidthW16: sx = {{16{raw_word_i[15]}}, raw_word_i[15:0]};
      WidthW24: sx = {{8{raw_word_i[23]}}, raw_word_i[23:0]};
      WidthW32: sx = raw_word_i;
      default:  sx = {{16{raw_word_i[15]}}, raw_word_i[15:0]};
    endcase
  end

  assign fs   = full_scale(mode_i);
  assign mag  = sx[31] ? (32'd0 - sx) : sx;
  assign clip = (mag >= fs);
  assign magc = clip ? fs[30:0] : mag[30:0];

  // m / (2^n - 1) is the n-bit digit m repeated, so the Q2.30 quotient
  // is the top 30 bits of that repeating pattern
  always_comb begin
    unique case (mode_i)
      WidthW8:  frac = {magc[6:0], magc[6:0], magc[6:0], magc[6:0], magc[6:5]};
      WidthW16: frac = {magc[14:0], magc[14:0]};
      WidthW24: frac = {magc[22:0], magc[22:16]};
      WidthW32: frac = magc[30:1];
      default:  frac = {magc[14:0], magc[14:0]};
    endcase
  end

  assign level_abs = clip ? LevelOne : {1'b0, frac};

  assign sample_o.channel   = channel_i;
  assign sample_o.level     = sx[31] ? (32'd0 - {1'b0, level_abs}) : {1'b0, level_abs};
  assign sample_o.level_abs = level_abs;
  assign sample_o.clipped   = clip;
  assign sample_o.first     = first_of_block_i;

endmodule

`default_nettype wire

>>> hdl/pcpm_chan_mem.sv
`default_nettype none

module pcpm_chan_mem import pcpm_pkg::*; #(
  parameter int Channels = NumChannels
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  sample_t sample_i,
  input  logic    adv_i,
  output logic    s1_valid_o,
  output result_t result_o
);

  localparam int AW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int DW = 33;

  logic [DW-1:0]       mem_q [Channels];
  logic [Channels-1:0] valid_q;

  logic [AW+2:0] ch_ext;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;

  logic          s1_valid_q;
  sample_t       s1_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_in_range_q;
  logic [DW-1:0] rd_data_q;
  logic          rd_valid_q;
  logic          fwd_hit_q;
  logic [DW-1:0] fwd_data_q;

  logic [DW-1:0] cur;
  logic [1:0]    cur_run;
  logic [30:0]   cur_peak;
  logic [1:0]    run_d;
  logic [30:0]   peak_d;
  logic          wb_en;
  logic [DW-1:0] wb_data;

  assign ch_ext      = {{AW{1'b0}}, sample_i.channel};
  assign rd_addr     = ch_ext[AW-1:0];
  assign rd_in_range = ch_ext < (AW+3)'(Channels);

  // Merge: a first-of-block item starts from zero, else forward the write
  // that landed on the accept edge, else the stored entry if valid
  always_comb begin
    if (s1_q.first) begin
      cur = '0;
    end else if (fwd_hit_q) begin
      cur = fwd_data_q;
    end else if (rd_valid_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  assign cur_run  = cur[32:31];
  assign cur_peak = cur[30:0];

  always_comb begin
    if (cur_run < ClipRunMax) begin
      run_d = s1_q.clipped ? (cur_run + 2'd1) : 2'd0;
    end else begin
      run_d = cur_run;
    end
  end

  assign peak_d  = (s1_q.level_abs > cur_peak) ? s1_q.level_abs : cur_peak;
  assign wb_en   = s1_valid_q && adv_i && s1_in_range_q;
  assign wb_data = {run_d, peak_d};

  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      mem_q[s1_addr_q] <= wb_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_q          <= sample_i;
      s1_addr_q     <= rd_addr;
      s1_in_range_q <= rd_in_range;
      fwd_hit_q     <= wb_en && (s1_addr_q == rd_addr);
      fwd_data_q    <= wb_data;
      if (rd_in_range) begin
        rd_data_q  <= mem_q[rd_addr];
        rd_valid_q <= valid_q[rd_addr];
      end else begin
        rd_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= '0;
    end else begin
      if (in_fire_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
      // a block start wipes everything, including an older write this edge
      if (in_fire_i && sample_i.first) begin
        valid_q <= '0;
      end else if (wb_en) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  assign s1_valid_o       = s1_valid_q;
  assign result_o.channel = s1_q.channel;
  assign result_o.level   = s1_q.level;
  assign result_o.peak    = s1_in_range_q ? peak_d : s1_q.level_abs;
  assign result_o.over    = s1_in_range_q && (run_d == ClipRunMax);
  assign result_o.clipped = s1_q.clipped;

endmodule

`default_nettype wire

>>> hdl/pcpm_checker.sv
`default_nettype none

module pcpm_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire [2:0]         channel_out_o,
  input wire signed [31:0] level_sample_o,
  input wire [30:0]        peak_level_o,
  input wire               over_flag_o,
  input wire               clipped_o
);

  logic [31:0] lvl_abs;

  assign lvl_abs = level_sample_o[31] ? (32'd0 - level_sample_o) : level_sample_o;

  // an accepted item is followed by a raised out_valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> ##2 out_valid_o)
    else $error("accepted item produced no result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(level_sample_o)
      && $stable(peak_level_o) && $stable(channel_out_o)))
    else $error("stalled result changed");

  a_clip_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (lvl_abs == 32'h4000_0000))
    else $error("clipped item not at full scale");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, peak_level_o} >= lvl_abs
      && peak_level_o <= 31'h4000_0000))
    else $error("peak below item level or above full scale");

  // a raised over flag means the channel already held a full-scale item
  a_over_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && over_flag_o) |-> (peak_level_o == 31'h4000_0000))
    else $error("over flag without a full-scale peak");

endmodule

bind pcm_capture_clip_and_peak_meter pcpm_checker u_pcpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .channel_out_o    (channel_out_o),
  .level_sample_o   (level_sample_o),
  .peak_level_o     (peak_level_o),
  .over_flag_o      (over_flag_o),
  .clipped_o        (clipped_o)
);

`default_nettype wire

>>> dv/pcm_level_checker.sv
`timescale 1ns / 100ps

module pcm_level_checker import pcpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] raw_word_i,
  input  logic [2:0]  channel_i,
  input  logic        first_of_block_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  channel_out_i,
  input  logic [31:0] level_sample_i,
  input  logic [30:0] peak_level_i,
  input  logic        over_flag_i,
  input  logic        clipped_i,
  output int          pending_o,
  output int          fails_o,
  output int          results_o,
  output int          clips_o,
  output int          overs_o
);

  width_e      width_mode;
  logic [30:0] peak_mem [NumChannels];
  logic [1:0]  run_mem  [NumChannels];
  result_t     level_q  [$];

  function automatic int unsigned sample_bits(width_e m);
    case (m)
      WidthW8:  return 8;
      WidthW16: return 16;
      WidthW24: return 24;
      default:  return 32;
    endcase
  endfunction

  // Condition one sample and update the channel's peak and clip run.
  function automatic result_t meter_sample(logic [31:0] raw, logic [2:0] ch, logic first);
    int unsigned b;
    logic [63:0] fs, v, mag, lvl_abs;
    logic        neg, clip;
    logic [1:0]  run;
    result_t     r;
    b = sample_bits(width_mode);
    fs = (64'd1 << (b - 1)) - 64'd1;
    v = {32'd0, raw} & ((64'd1 << b) - 64'd1);
    neg = v[b - 1];
    mag = neg ? (64'd1 << b) - v : v;
    clip = (mag >= fs);
    if (clip) mag = fs;
    lvl_abs = (mag << 30) / fs;
    if (first) begin
      for (int c = 0; c < NumChannels; c++) begin
        peak_mem[c] = '0;
        run_mem[c] = '0;
      end
    end
    run = run_mem[ch];
    // a run of three sticks until the block is cleared
    if (run < ClipRunMax) run = clip ? run + 2'd1 : 2'd0;
    run_mem[ch] = run;
    if (lvl_abs[30:0] > peak_mem[ch]) peak_mem[ch] = lvl_abs[30:0];
    r.channel = ch;
    r.level   = neg ? -lvl_abs[31:0] : lvl_abs[31:0];
    r.peak    = peak_mem[ch];
    r.over    = (run == ClipRunMax);
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h", $time, results_o, what, got,
             want);
    fails_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      width_mode = WidthReset;
      for (int c = 0; c < NumChannels; c++) begin
        peak_mem[c] = '0;
        run_mem[c] = '0;
      end
      level_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (level_q.size() == 0) begin
          report_mismatch("item with nothing expected", channel_out_i, 0);
        end else begin
          want = level_q.pop_front();
          if (channel_out_i !== want.channel)
            report_mismatch("channel_out", channel_out_i, want.channel);
          if (level_sample_i !== want.level)
            report_mismatch("level_sample", level_sample_i, want.level);
          if (peak_level_i !== want.peak)
            report_mismatch("peak_level", peak_level_i, want.peak);
          if (over_flag_i !== want.over)
            report_mismatch("over_flag", over_flag_i, want.over);
          if (clipped_i !== want.clipped)
            report_mismatch("clipped", clipped_i, want.clipped);
          clips_o += want.clipped;
          overs_o += want.over;
        end
      end
      if (in_valid_i && in_ready_i)
        level_q.push_back(meter_sample(raw_word_i, channel_i, first_of_block_i));
      if (cfg_we_i) width_mode = width_e'(cfg_wdata_i);
      pending_o = level_q.size();
    end
  end

endmodule

>>> dv/pcm_capture_clip_and_peak_meter_test.sv
`timescale 1ns / 100ps

module pcm_capture_clip_and_peak_meter_test;
  import pcpm_pkg::*;

  localparam int KindNearPos  = 0;
  localparam int KindNearNeg  = 1;
  localparam int KindSmall    = 2;
  localparam int StallCycles  = 80;
  localparam int PhaseItems   = 103;
  localparam int PressurePhase = 2;
  localparam int QuietPhase    = 5;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] raw_word;
  logic [2:0]  channel;
  logic        first_of_block;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  channel_out;
  logic [31:0] level_sample;
  logic [30:0] peak_level;
  logic        over_flag;
  logic        clipped;

  int pending, fails, results, clips, overs;
  int unsigned items_sent;
  int hold_left;
  bit stall_req, stall_taken, rx_quiet;

  width_e phase_modes [8] = '{WidthW16, WidthW8, WidthW32, WidthW24,
                              WidthW8, WidthW32, WidthW16, WidthW24};

  pcm_capture_clip_and_peak_meter DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_word_i       (raw_word),
    .channel_i        (channel),
    .first_of_block_i (first_of_block),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .channel_out_o    (channel_out),
    .level_sample_o   (level_sample),
    .peak_level_o     (peak_level),
    .over_flag_o      (over_flag),
    .clipped_o        (clipped)
  );

  pcm_level_checker level_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .raw_word_i       (raw_word),
    .channel_i        (channel),
    .first_of_block_i (first_of_block),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .channel_out_i    (channel_out),
    .level_sample_i   (level_sample),
    .peak_level_i     (peak_level),
    .over_flag_i      (over_flag),
    .clipped_i        (clipped),
    .pending_o        (pending),
    .fails_o          (fails),
    .results_o        (results),
    .clips_o          (clips),
    .overs_o          (overs)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned sample_bits(width_e m);
    case (m)
      WidthW8:  return 8;
      WidthW16: return 16;
      WidthW24: return 24;
      default:  return 32;
    endcase
  endfunction

  function automatic longint full_of(width_e m);
    return (longint'(1) << (sample_bits(m) - 1)) - 1;
  endfunction

  // Place a signed sample in the low bits and fill the unused bits at random.
  function automatic logic [31:0] pack_word(width_e m, longint s);
    logic [63:0] mask, w;
    mask = (64'd1 << sample_bits(m)) - 64'd1;
    w = ({32'd0, $urandom} & ~mask) | (64'(s) & mask);
    return w[31:0];
  endfunction

  function automatic longint pick_sample(width_e m, int kind);
    case (kind)
      KindNearPos: return full_of(m) - longint'($urandom_range(0, 3));
      KindNearNeg: return -full_of(m) - 1 + longint'($urandom_range(0, 4));
      default:     return longint'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  // Enter at a falling edge; leave at the falling edge after the item is taken.
  task automatic send_item(logic [31:0] raw, logic [2:0] ch, logic first);
    in_valid = 1'b1;
    raw_word = raw;
    channel = ch;
    first_of_block = first;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic sender_gap(bit quiet);
    int r, g;
    if (quiet) return;
    r = $urandom_range(0, 99);
    if (r < 65) g = 0;
    else if (r < 93) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // Drain the pipeline, then write the sample width.
  task automatic set_width(width_e m);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic random_phase(width_e m, int count, bit quiet);
    int done, r, len, kind;
    logic [2:0]  ch;
    logic [31:0] raw;
    logic        first;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // run of mostly near-full-scale samples on one channel
        ch = 3'($urandom_range(0, 7));
        len = $urandom_range(2, 5);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) kind = KindSmall;
          else kind = $urandom_range(0, 1) ? KindNearPos : KindNearNeg;
          send_item(pack_word(m, pick_sample(m, kind)), ch, 1'b0);
          sender_gap(quiet);
          done++;
        end
      end else begin
        ch = 3'($urandom_range(0, 7));
        first = ($urandom_range(0, 39) == 0);
        if (r < 55) raw = $urandom;
        else raw = pack_word(m, pick_sample(m, $urandom_range(KindNearPos, KindSmall)));
        send_item(raw, ch, first);
        sender_gap(quiet);
        done++;
      end
    end
  endtask

  initial begin
    width_e w;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = WidthReset;
    in_valid = 1'b0;
    raw_word = '0;
    channel = '0;
    first_of_block = 1'b0;
    stall_req = 1'b0;
    rx_quiet = 1'b0;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // extremes of every width, junk in the unused bits
    for (int m = 0; m < 4; m++) begin
      w = width_e'(m);
      set_width(w);
      send_item(pack_word(w, full_of(w)), 3'd0, 1'b1);
      send_item(pack_word(w, -full_of(w) - 1), 3'd1, 1'b0);
      send_item(pack_word(w, -full_of(w)), 3'd2, 1'b0);
      send_item(pack_word(w, full_of(w) - 1), 3'd3, 1'b0);
      send_item(pack_word(w, 0), 3'd7, 1'b0);
    end
    // three clips raise the over flag, an unclipped sample keeps it, a new block clears it
    send_item(pack_word(w, full_of(w)), 3'd6, 1'b0);
    send_item(pack_word(w, -full_of(w)), 3'd6, 1'b0);
    send_item(pack_word(w, -full_of(w) - 1), 3'd6, 1'b0);
    send_item(pack_word(w, 5), 3'd6, 1'b0);
    send_item(pack_word(w, -5), 3'd6, 1'b1);

    for (int p = 0; p < 8; p++) begin
      set_width(phase_modes[p]);
      rx_quiet = (p == QuietPhase);
      stall_req = (p == PressurePhase);
      random_phase(phase_modes[p], PhaseItems, p == PressurePhase || p == QuietPhase);
    end

    in_valid = 1'b0;
    rx_quiet = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("Sent %0d items across all four sample widths, with random gaps on both sides",
             items_sent);
    $display("and one long output stall; %0d results compared, %0d clipped, %0d over.",
             results, clips, overs);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    stall_taken = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        out_ready = 1'b0;
        hold_left = StallCycles - 1;
      end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
